// ===== design/crs4_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs4_pkg
// Shared types, constants and the skew matrix layout for the Cayley
// retraction onto SO(4).
// ----------------------------------------------------------------------------
package crs4_pkg;

    localparam int GEN_W   = 16;
    localparam int NUM_GEN = 6;
    localparam int GENS_W  = GEN_W * NUM_GEN;
    localparam int Y_W     = GEN_W + 1;
    localparam int ENT_W   = 16;
    localparam int LAST_ROW = 3;

    typedef logic [GENS_W-1:0]    gens_t;
    typedef logic signed [Y_W-1:0] yent_t;
    typedef logic [1:0]           row_t;

    // Control that travels beside each row through the pipeline.
    typedef struct packed {
        logic vld;
        row_t row;
    } rowtag_t;

    // Entry (r, c) of the skew-symmetric matrix built from the six components.
    function automatic yent_t y_entry(input gens_t g, input row_t r, input row_t c);
        yent_t e [NUM_GEN];
        yent_t res;
        for (int n = 0; n < NUM_GEN; n++) begin
            e[n] = {g[GEN_W*n+GEN_W-1], g[GEN_W*n +: GEN_W]};
        end
        unique case ({r, c})
            4'b0001: res = -e[5];
            4'b0010: res = e[4];
            4'b0011: res = e[2];
            4'b0100: res = e[5];
            4'b0110: res = -e[3];
            4'b0111: res = -e[1];
            4'b1000: res = -e[4];
            4'b1001: res = e[3];
            4'b1011: res = e[0];
            4'b1100: res = -e[2];
            4'b1101: res = e[1];
            4'b1110: res = -e[0];
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

// ===== design/crs4_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs4_div
// Four-lane pipelined restoring divider, one quotient bit per stage, with
// round to nearest and saturation to a signed 16-bit entry.
// ----------------------------------------------------------------------------
module crs4_div #(
    parameter int DW   = 66,
    parameter int FRAC = 14
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  crs4_pkg::rowtag_t         in_tag,
    input  logic [DW-1:0]             in_mag [4],
    input  logic                      in_neg [4],
    input  logic [DW-1:0]             in_den,
    output crs4_pkg::rowtag_t         out_tag,
    output logic signed [crs4_pkg::ENT_W-1:0] out_entry [4]
);
    import crs4_pkg::*;

    localparam int QS = FRAC + 2;
    localparam int RW = QS + 17;

    rowtag_t       tag_reg [QS];
    logic [DW-1:0] den_reg [QS];
    logic [DW-1:0] rem_reg [QS][4];
    logic [QS-1:0] q_reg   [QS][4];
    logic          neg_reg [QS][4];

    logic [DW-1:0] rem_next [QS][4];
    logic          bit_next [QS][4];

    // Stage 0 finds the integer bit (magnitude at least the divisor).
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            bit_next[0][l] = (in_mag[l] >= in_den);
            rem_next[0][l] = bit_next[0][l] ? in_mag[l] - in_den : in_mag[l];
        end
    end

    for (genvar s = 1; s < QS; s++) begin : g_stage
        always_comb begin
            logic [DW:0] r2;
            for (int l = 0; l < 4; l++) begin
                r2 = {rem_reg[s-1][l], 1'b0};
                bit_next[s][l] = (r2 >= {1'b0, den_reg[s-1]});
                rem_next[s][l] = bit_next[s][l] ? DW'(r2 - {1'b0, den_reg[s-1]})
                                                : DW'(r2);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < QS; s++) begin
                tag_reg[s] <= '0;
            end
        end else if (en) begin
            tag_reg[0] <= in_tag;
            for (int s = 1; s < QS; s++) begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0] <= in_den;
            for (int l = 0; l < 4; l++) begin
                rem_reg[0][l] <= rem_next[0][l];
                q_reg[0][l]   <= QS'(bit_next[0][l]);
                neg_reg[0][l] <= in_neg[l];
            end
            for (int s = 1; s < QS; s++) begin
                den_reg[s] <= den_reg[s-1];
                for (int l = 0; l < 4; l++) begin
                    rem_reg[s][l] <= rem_next[s][l];
                    q_reg[s][l]   <= {q_reg[s-1][l][QS-2:0], bit_next[s][l]};
                    neg_reg[s][l] <= neg_reg[s-1][l];
                end
            end
        end
    end

    // The quotient carries one extra fraction bit; (t + 1) / 2 rounds it.
    always_comb begin
        logic [RW-1:0] rq;
        for (int l = 0; l < 4; l++) begin
            rq = (RW'(q_reg[QS-1][l]) + RW'(1)) >> 1;
            if (neg_reg[QS-1][l]) begin
                out_entry[l] = (rq > RW'(32768)) ? 16'sh8000 : -$signed(rq[ENT_W-1:0]);
            end else begin
                out_entry[l] = (rq > RW'(32767)) ? 16'sh7FFF : $signed(rq[ENT_W-1:0]);
            end
        end
    end

    assign out_tag = tag_reg[QS-1];

endmodule

// ===== design/cayley_retract_so4.sv =====
`timescale 1ns / 1ps
// Path: m_tvalid rises for the first row of a word once the word has passed the
// row sequencer, six arithmetic stages, OUT_FRAC_BITS + 2 divider stages and
// the output register. The other rows follow one per cycle while the pipeline
// is not stalled by m_tready.
// Throughput: the row sequencer feeds the four rows of a word into the pipeline
// and takes a new word as the last row enters; one result row per cycle unless stalled.
// Reset clears every valid bit and the sequencer; data registers are not reset.
// ----------------------------------------------------------------------------
// cayley_retract_so4
// Cayley retraction of a six-component tangent vector onto a 4x4 rotation,
// delivered as four rows of Q1.14 entries.
// ----------------------------------------------------------------------------
module cayley_retract_so4 #(
    parameter int IN_FRAC_BITS  = 12,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // gen_0 [15:0], gen_1 [31:16], gen_2 [47:32], gen_3 [63:48],
    // gen_4 [79:64], gen_5 [95:80]
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // row_index [1:0], entry_col0 [17:2], entry_col1 [33:18],
    // entry_col2 [49:34], entry_col3 [65:50], zero padding [71:66]
    output logic [71:0] m_tdata,
    // last_row
    output logic        m_tlast
);
    import crs4_pkg::*;

    // With scale D = 2^K the rotation is R = N / Den, where
    //   Den = D^4 + S*D^2 + P^2 and
    //   N   = 2(D^2 + S)*Y*D + 2*Y^2*D^2 + 2*Y^3*D + (D^4 + S*D^2 - P^2)*I,
    // S being the sum of squares and P the Pfaffian of the integer matrix Y.
    localparam int K   = IN_FRAC_BITS + 1;
    localparam int SW  = 34;
    localparam int PW  = 32;
    localparam int DA  = (4 * K > 2 * K + SW) ? 4 * K : 2 * K + SW;
    localparam int DW  = ((DA > 2 * PW) ? DA : 2 * PW) + 2;
    localparam int NW  = DW + 1;
    localparam int P2W = 2 * Y_W;
    localparam int Y2W = P2W + 2;
    localparam int P3W = Y2W + Y_W;
    localparam int Y3W = P3W + 2;
    localparam int YSW = Y_W + SW + 1;

    logic pipe_en;
    logic accept;

    // ---------------- Row sequencer ----------------
    // Holds one word and walks its four rows into the pipeline.
    logic  busy_reg;
    row_t  row_reg;
    gens_t gen_reg;

    assign pipe_en  = !m_tvalid || m_tready;
    assign s_tready = pipe_en && (!busy_reg || row_reg == row_t'(LAST_ROW));
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
        end else if (pipe_en) begin
            if (accept) begin
                busy_reg <= 1'b1;
                row_reg  <= '0;
            end else if (busy_reg) begin
                row_reg  <= row_reg + row_t'(1);
                busy_reg <= (row_reg != row_t'(LAST_ROW));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            gen_reg <= s_tdata;
        end
    end

    // ---------------- Stage 1: row of Y and first products ----------------
    rowtag_t                t1_reg;
    gens_t                  g1_reg;
    yent_t                  yr1_reg [4];
    logic signed [P2W-1:0]  p2_1_reg [4][4];
    logic [2*GEN_W-1:0]     sq1_reg [NUM_GEN];
    logic signed [P2W-1:0]  pf1_reg [3];

    logic signed [P2W-1:0]  p2_next [4][4];
    logic [2*GEN_W-1:0]     sq_next [NUM_GEN];
    yent_t                  yr_next [4];

    always_comb begin
        logic signed [2*GEN_W-1:0] gv;
        for (int m = 0; m < 4; m++) begin
            yr_next[m] = y_entry(gen_reg, row_reg, row_t'(m));
        end
        for (int j = 0; j < 4; j++) begin
            for (int m = 0; m < 4; m++) begin
                p2_next[j][m] = yr_next[m] * y_entry(gen_reg, row_t'(m), row_t'(j));
            end
        end
        for (int n = 0; n < NUM_GEN; n++) begin
            gv = $signed(gen_reg[GEN_W*n +: GEN_W]);
            sq_next[n] = $unsigned(gv * gv);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg <= '0;
        end else if (pipe_en) begin
            t1_reg.vld <= busy_reg;
            t1_reg.row <= row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            g1_reg   <= gen_reg;
            yr1_reg  <= yr_next;
            p2_1_reg <= p2_next;
            sq1_reg  <= sq_next;
            pf1_reg[0] <= y_entry(gen_reg, 2'd0, 2'd1) * y_entry(gen_reg, 2'd2, 2'd3);
            pf1_reg[1] <= y_entry(gen_reg, 2'd0, 2'd2) * y_entry(gen_reg, 2'd1, 2'd3);
            pf1_reg[2] <= y_entry(gen_reg, 2'd0, 2'd3) * y_entry(gen_reg, 2'd1, 2'd2);
        end
    end

    // ---------------- Stage 2: row of Y^2, S and Pfaffian ----------------
    rowtag_t               t2_reg;
    gens_t                 g2_reg;
    yent_t                 yr2_reg [4];
    logic signed [Y2W-1:0] y2_2_reg [4];
    logic [SW-1:0]         s2_reg;
    logic signed [Y2W-1:0] pf2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t2_reg <= '0;
        end else if (pipe_en) begin
            t2_reg <= t1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic [SW-1:0] sacc;
        if (pipe_en) begin
            g2_reg  <= g1_reg;
            yr2_reg <= yr1_reg;
            for (int j = 0; j < 4; j++) begin
                y2_2_reg[j] <= Y2W'(p2_1_reg[j][0]) + Y2W'(p2_1_reg[j][1])
                             + Y2W'(p2_1_reg[j][2]) + Y2W'(p2_1_reg[j][3]);
            end
            sacc = '0;
            for (int n = 0; n < NUM_GEN; n++) begin
                sacc = sacc + SW'(sq1_reg[n]);
            end
            s2_reg  <= sacc;
            pf2_reg <= Y2W'(pf1_reg[0]) - Y2W'(pf1_reg[1]) + Y2W'(pf1_reg[2]);
        end
    end

    // ---------------- Stage 3: products for Y^3 and Y*S ----------------
    rowtag_t               t3_reg;
    yent_t                 yr3_reg [4];
    logic signed [Y2W-1:0] y2_3_reg [4];
    logic [SW-1:0]         s3_reg;
    logic signed [P3W-1:0] p3_3_reg [4][4];
    logic signed [YSW-1:0] ys3_reg [4];
    logic [PW-1:0]         apf3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t3_reg <= '0;
        end else if (pipe_en) begin
            t3_reg <= t2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [Y2W-1:0] apf;
        if (pipe_en) begin
            yr3_reg  <= yr2_reg;
            y2_3_reg <= y2_2_reg;
            s3_reg   <= s2_reg;
            for (int j = 0; j < 4; j++) begin
                for (int m = 0; m < 4; m++) begin
                    p3_3_reg[j][m] <= y2_2_reg[m] * y_entry(g2_reg, row_t'(m), row_t'(j));
                end
                ys3_reg[j] <= yr2_reg[j] * $signed({1'b0, s2_reg});
            end
            apf = pf2_reg[Y2W-1] ? -pf2_reg : pf2_reg;
            apf3_reg <= apf[PW-1:0];
        end
    end

    // ---------------- Stage 4: row of Y^3 and P^2 ----------------
    rowtag_t               t4_reg;
    yent_t                 yr4_reg [4];
    logic signed [Y2W-1:0] y2_4_reg [4];
    logic signed [Y3W-1:0] y3_4_reg [4];
    logic signed [YSW-1:0] ys4_reg [4];
    logic [SW-1:0]         s4_reg;
    logic [2*PW-1:0]       pp4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t4_reg <= '0;
        end else if (pipe_en) begin
            t4_reg <= t3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            yr4_reg  <= yr3_reg;
            y2_4_reg <= y2_3_reg;
            ys4_reg  <= ys3_reg;
            s4_reg   <= s3_reg;
            for (int j = 0; j < 4; j++) begin
                y3_4_reg[j] <= Y3W'(p3_3_reg[j][0]) + Y3W'(p3_3_reg[j][1])
                             + Y3W'(p3_3_reg[j][2]) + Y3W'(p3_3_reg[j][3]);
            end
            pp4_reg <= apf3_reg * apf3_reg;
        end
    end

    // ---------------- Stage 5: denominator and partial numerators ----------------
    // The numerator is known to stay within the denominator in magnitude, so
    // all terms are summed modulo 2^NW without loss.
    rowtag_t              t5_reg;
    logic [DW-1:0]        den5_reg;
    logic signed [NW-1:0] diag5_reg;
    logic signed [NW-1:0] ta5_reg [4];
    logic signed [NW-1:0] tb5_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t5_reg <= '0;
        end else if (pipe_en) begin
            t5_reg <= t4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic [DW-1:0] base;
        if (pipe_en) begin
            base = (DW'(1) << (4 * K)) + (DW'(s4_reg) << (2 * K));
            den5_reg  <= base + DW'(pp4_reg);
            diag5_reg <= $signed(NW'(base)) - $signed(NW'(pp4_reg));
            for (int j = 0; j < 4; j++) begin
                ta5_reg[j] <= (NW'(yr4_reg[j]) <<< (3 * K + 1))
                            + (NW'(ys4_reg[j]) <<< (K + 1));
                tb5_reg[j] <= (NW'(y2_4_reg[j]) <<< (2 * K + 1))
                            + (NW'(y3_4_reg[j]) <<< (K + 1));
            end
        end
    end

    // ---------------- Stage 6: numerator, sign and magnitude ----------------
    rowtag_t       t6_reg;
    logic [DW-1:0] den6_reg;
    logic [DW-1:0] mag6_reg [4];
    logic          neg6_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t6_reg <= '0;
        end else if (pipe_en) begin
            t6_reg <= t5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [NW-1:0] num;
        logic signed [NW-1:0] amag;
        if (pipe_en) begin
            den6_reg <= den5_reg;
            for (int j = 0; j < 4; j++) begin
                num = ta5_reg[j] + tb5_reg[j]
                    + ((t5_reg.row == row_t'(j)) ? diag5_reg : NW'(0));
                amag = num[NW-1] ? -num : num;
                neg6_reg[j] <= num[NW-1];
                mag6_reg[j] <= amag[DW-1:0];
            end
        end
    end

    // ---------------- Divider: entry = round(mag * 2^F / den) ----------------
    rowtag_t                 div_tag;
    logic signed [ENT_W-1:0] div_entry [4];

    crs4_div #(
        .DW   (DW),
        .FRAC (OUT_FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_tag    (t6_reg),
        .in_mag    (mag6_reg),
        .in_neg    (neg6_reg),
        .in_den    (den6_reg),
        .out_tag   (div_tag),
        .out_entry (div_entry)
    );

    // ---------------- Output register ----------------
    // The whole pipeline advances whenever this register is empty or drained.
    logic        m_valid_reg;
    logic [71:0] m_data_reg;
    logic        m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= div_tag.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_data_reg <= {6'b0, div_entry[3], div_entry[2], div_entry[1], div_entry[0],
                           div_tag.row};
            m_last_reg <= (div_tag.row == row_t'(LAST_ROW));
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== test/crs4_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs4_checker
// Watches both stream channels of the Cayley retraction and computes each
// rotation row with exact wide integer arithmetic. It then compares every row
// that leaves the block, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module crs4_checker
    import crs4_pkg::*;
#(
    parameter int IN_FRAC_BITS  = 12,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic        aclk,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatches,
    output int          rows_owed
);

    localparam int K = IN_FRAC_BITS + 1;

    typedef struct {
        logic [71:0] data;
        logic        last;
    } rot_row_t;

    rot_row_t rot_rows_q[$];

    assign rows_owed = rot_rows_q.size();

    // One entry R(r, c), rounded to nearest with ties away from zero, saturated.
    function automatic logic [15:0] cayley_entry(input logic [95:0] g, input int r,
                                                 input int c);
        longint gv [6];
        longint y [4][4];
        longint y2 [4][4];
        longint y3 [4][4];
        longint s, pf, acc;
        logic signed [127:0] pp, base, den, diag, n, mag, q, lin;
        s = 0;
        for (int i = 0; i < 6; i++) begin
            gv[i] = longint'($signed(g[16*i +: 16]));
            s += gv[i] * gv[i];
        end
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) y[i][j] = 0;
        y[0][1] = -gv[5]; y[0][2] = gv[4];  y[1][2] = -gv[3];
        y[0][3] = gv[2];  y[1][3] = -gv[1]; y[2][3] = gv[0];
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < i; j++) y[i][j] = -y[j][i];
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) begin
                acc = 0;
                for (int m = 0; m < 4; m++) acc += y[i][m] * y[m][j];
                y2[i][j] = acc;
            end
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) begin
                acc = 0;
                for (int m = 0; m < 4; m++) acc += y2[i][m] * y[m][j];
                y3[i][j] = acc;
            end
        pf = y[0][1] * y[2][3] - y[0][2] * y[1][3] + y[0][3] * y[1][2];
        pp = pf;
        pp = pp * pp;
        base = 128'sd1 <<< (4 * K);
        n = s;
        base = base + (n <<< (2 * K));
        den = base + pp;
        diag = base - pp;
        lin = y[r][c];
        n = s;
        lin = lin * ((128'sd1 <<< (2 * K)) + n) * 2;
        n = lin <<< K;
        lin = y2[r][c];
        n = n + ((lin * 2) <<< (2 * K));
        lin = y3[r][c];
        n = n + ((lin * 2) <<< K);
        if (r == c) n = n + diag;
        mag = (n < 0) ? -n : n;
        q = ((mag <<< (OUT_FRAC_BITS + 1)) + den) / (den * 2);
        if (n < 0) return (q > 32768) ? 16'h8000 : 16'(-q);
        return (q > 32767) ? 16'h7fff : 16'(q);
    endfunction

    initial mismatches = 0;

    always @(posedge aclk) begin
        rot_row_t want;
        rot_row_t row;
        if (s_tvalid && s_tready) begin
            for (int r = 0; r < 4; r++) begin
                row.data = '0;
                row.data[1:0] = row_t'(r);
                for (int c = 0; c < 4; c++)
                    row.data[2 + 16*c +: 16] = cayley_entry(s_tdata, r, c);
                row.last = (r == LAST_ROW);
                rot_rows_q.push_back(row);
            end
        end
        if (m_tvalid && m_tready) begin
            if (rot_rows_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected row, got data %h last %b", $time, m_tdata, m_tlast);
            end else begin
                want = rot_rows_q.pop_front();
                if (m_tdata[1:0] !== want.data[1:0]) begin
                    mismatches++;
                    $display("%0t: row_index expected %0d, got %0d", $time,
                             want.data[1:0], m_tdata[1:0]);
                end
                for (int c = 0; c < 4; c++)
                    if (m_tdata[2 + 16*c +: 16] !== want.data[2 + 16*c +: 16]) begin
                        mismatches++;
                        $display("%0t: row %0d entry_col%0d expected %0d, got %0d", $time,
                                 want.data[1:0], c, $signed(want.data[2 + 16*c +: 16]),
                                 $signed(m_tdata[2 + 16*c +: 16]));
                    end
                if (m_tdata[71:66] !== 6'd0) begin
                    mismatches++;
                    $display("%0t: padding expected 0, got %h", $time, m_tdata[71:66]);
                end
                if (m_tlast !== want.last) begin
                    mismatches++;
                    $display("%0t: last_row expected %b, got %b", $time, want.last, m_tlast);
                end
            end
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the Cayley retraction. Directed tangent vectors
// come first: zero, each component alone at its extremes, all and mixed extremes,
// magnitudes of one, the smallest magnitudes and alternating bit patterns. Random
// vectors follow, with random gaps on both sides and one long receiver hold so that
// the pipeline fills and stalls its input.
module tb;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_WORDS   = 250;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;

    int mismatches;
    int rows_owed;
    int rows_taken;
    int idle_cycles = 0;

    logic [95:0] directed_q[$];

    cayley_retract_so4 i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    crs4_checker i_checker (
        .aclk       (aclk),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .rows_owed  (rows_owed)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // A component is either fully random or kept near unit magnitude, where
    // the rotation entries vary the most.
    function automatic logic [15:0] random_gen();
        if ($urandom_range(0, 2) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 12288)) - 6144);
    endfunction

    // The watchdog counts cycles in which neither channel moves a word.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL cayley_retract_so4");
            $finish;
        end
    end

    // Receiver: random stalls in busy phases, none in quiet phases, and one
    // long hold once a few dozen rows have been taken.
    initial begin
        bit busy;
        bit held;
        int stall;
        busy = 1'b1;
        held = 1'b0;
        rows_taken = 0;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!held && rows_taken >= 60) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = busy ? $urandom_range(0, 3) : 0;
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            rows_taken++;
            if ($urandom_range(0, 29) == 0) busy = !busy;
        end
    end

    // Sender: directed words first, then random ones, with random gaps in busy phases.
    initial begin
        logic [95:0] word;
        int gap;
        bit busy;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        busy = 1'b1;

        directed_q.push_back('0);
        for (int n = 0; n < 6; n++) begin
            word = '0;
            word[16*n +: 16] = 16'h7fff;
            directed_q.push_back(word);
            word[16*n +: 16] = 16'h8000;
            directed_q.push_back(word);
        end
        directed_q.push_back({6{16'h7fff}});
        directed_q.push_back({6{16'h8000}});
        directed_q.push_back({3{16'h8000, 16'h7fff}});
        directed_q.push_back({6{16'h1000}});
        directed_q.push_back({6{16'hf000}});
        directed_q.push_back({6{16'h0001}});
        directed_q.push_back({6{16'hffff}});
        directed_q.push_back({3{16'haaaa, 16'h5555}});

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < directed_q.size() + RANDOM_WORDS; i++) begin
            if (i < directed_q.size()) begin
                word = directed_q[i];
            end else begin
                for (int n = 0; n < 6; n++) word[16*n +: 16] = random_gen();
            end
            s_tvalid <= 1'b1;
            s_tdata  <= word;
            do @(posedge aclk); while (!s_tready);
            if ($urandom_range(0, 24) == 0) busy = !busy;
            gap = busy ? $urandom_range(0, 3) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;

        // Let the checker log the last word, drain, then allow for latency.
        @(posedge aclk);
        wait (rows_owed == 0);
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS cayley_retract_so4");
        end else begin
            $display("FAIL cayley_retract_so4");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/crs4_pkg.sv
design/crs4_div.sv
design/cayley_retract_so4.sv
test/crs4_checker.sv
test/tb.sv
